/* hw/rtl/tgsd_pkg.sv */
// Package for the ternary group-scaled dot product core.
// Holds widths, code values, register indexes and the structs passed between stages.
// No dependencies.
package tgsd_pkg;

  localparam int LANES       = 4;
  localparam int ACT_W       = 16;
  localparam int SCALE_W     = 16;
  localparam int COL_W       = 13;
  localparam int GB_W        = 11;
  localparam int BIG_W       = 10;
  localparam int PART_W      = 28;
  localparam int PROD_W      = PART_W + SCALE_W;
  localparam int ACC_W       = 56;
  localparam int CNT_W       = 13;
  localparam int LANE_W      = ACT_W + 1;
  localparam int SUM_W       = LANE_W + 2;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;

  localparam logic [COL_W-1:0] MAX_COLUMNS     = COL_W'(4096);
  localparam logic [GB_W-1:0]  MAX_GROUP_BYTES = GB_W'(1024);
  localparam logic [COL_W-1:0] RST_ACTIVE_COLS = COL_W'(4096);
  localparam logic [GB_W-1:0]  RST_GROUP_BYTES = GB_W'(16);

  localparam logic [1:0] CODE_ADD = 2'b01;
  localparam logic [1:0] CODE_SUB = 2'b10;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_BYTES = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [LANE_W-1:0] value;
    logic                     add;
    logic                     sub;
    logic                     skip;
  } lane_t;

  typedef struct packed {
    logic                      fold;
    logic                      last;
    logic signed [PART_W-1:0]  partial;
    logic signed [SCALE_W-1:0] scale;
    logic [CNT_W-1:0]          adds;
    logic [CNT_W-1:0]          subs;
    logic [CNT_W-1:0]          skips;
  } merge_t;

endpackage

/* hw/rtl/tgsd_lane.sv */
// One lane: decodes a 2-bit ternary code and registers the signed contribution and flags.
// Depends on tgsd_pkg.
module tgsd_lane import tgsd_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic [1:0]              code,
  input  logic signed [ACT_W-1:0] act,
  input  logic                    col_ok,
  output lane_t                   res
);

  logic                     is_add;
  logic                     is_sub;
  logic signed [LANE_W-1:0] act_ext;

  assign is_add  = col_ok && (code == CODE_ADD);
  assign is_sub  = col_ok && (code == CODE_SUB);
  assign act_ext = LANE_W'(act);

  always_ff @(posedge clk) begin
    if (load) begin
      res.add  <= is_add;
      res.sub  <= is_sub;
      res.skip <= col_ok && !is_add && !is_sub;
      if (is_add) begin
        res.value <= act_ext;
      end else if (is_sub) begin
        res.value <= -act_ext;
      end else begin
        res.value <= '0;
      end
    end
  end

endmodule

/* hw/rtl/tgsd_merge.sv */
// Merge stage: adds the lane results into the saturating group partial and the counts.
// Depends on tgsd_pkg.
module tgsd_merge import tgsd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  lane_t                     lanes [LANES],
  input  logic                      fold_in,
  input  logic                      last_in,
  input  logic signed [SCALE_W-1:0] scale_in,
  output merge_t                    res
);

  logic signed [PART_W-1:0]  partial;
  logic [CNT_W-1:0]          adds;
  logic [CNT_W-1:0]          subs;
  logic [CNT_W-1:0]          skips;
  logic signed [SUM_W-1:0]   lane_sum;
  logic [2:0]                n_add;
  logic [2:0]                n_sub;
  logic [2:0]                n_skip;
  logic signed [PART_W+1:0]  wide;
  logic signed [PART_W-1:0]  partial_next;
  logic [CNT_W-1:0]          adds_next;
  logic [CNT_W-1:0]          subs_next;
  logic [CNT_W-1:0]          skips_next;

  always_comb begin
    lane_sum = '0;
    n_add    = '0;
    n_sub    = '0;
    n_skip   = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum = lane_sum + SUM_W'($signed(lanes[i].value));
      n_add    = n_add + 3'(lanes[i].add);
      n_sub    = n_sub + 3'(lanes[i].sub);
      n_skip   = n_skip + 3'(lanes[i].skip);
    end
    wide = (PART_W+2)'(partial) + (PART_W+2)'(lane_sum);
    if (wide[PART_W+1:PART_W-1] == 3'b000 || wide[PART_W+1:PART_W-1] == 3'b111) begin
      partial_next = wide[PART_W-1:0];
    end else if (wide[PART_W+1]) begin
      partial_next = {1'b1, {(PART_W-1){1'b0}}};
    end else begin
      partial_next = {1'b0, {(PART_W-1){1'b1}}};
    end
    adds_next  = adds + CNT_W'(n_add);
    subs_next  = subs + CNT_W'(n_sub);
    skips_next = skips + CNT_W'(n_skip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      adds    <= '0;
      subs    <= '0;
      skips   <= '0;
    end else if (take) begin
      partial <= fold_in ? '0 : partial_next;
      adds    <= last_in ? '0 : adds_next;
      subs    <= last_in ? '0 : subs_next;
      skips   <= last_in ? '0 : skips_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.fold    <= fold_in;
      res.last    <= last_in;
      res.partial <= partial_next;
      res.scale   <= scale_in;
      res.adds    <= adds_next;
      res.subs    <= subs_next;
      res.skips   <= skips_next;
    end
  end

endmodule

/* hw/rtl/tgsd_mac.sv */
// Scale multiply, row accumulator and output register of the dot product core.
// Depends on tgsd_pkg.
module tgsd_mac import tgsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  merge_t                  grp,
  output logic                    v3,
  output logic                    last3,
  input  logic                    load3,
  input  logic                    adv3,
  output logic signed [ACC_W-1:0] dot_result,
  output logic [CNT_W-1:0]        add_count,
  output logic [CNT_W-1:0]        sub_count,
  output logic [CNT_W-1:0]        skip_count
);

  logic signed [PROD_W-1:0] prod;
  logic                     fold3;
  logic [CNT_W-1:0]         adds3;
  logic [CNT_W-1:0]         subs3;
  logic [CNT_W-1:0]         skips3;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (load3) begin
      v3 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod   <= grp.partial * grp.scale;
      fold3  <= grp.fold;
      last3  <= grp.last;
      adds3  <= grp.adds;
      subs3  <= grp.subs;
      skips3 <= grp.skips;
    end
  end

  assign acc_next = fold3 ? acc + ACC_W'(prod) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv3) begin
      acc <= last3 ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && last3) begin
      dot_result <= acc_next;
      add_count  <= adds3;
      sub_count  <= subs3;
      skip_count <= skips3;
    end
  end

endmodule

/* hw/rtl/ternary_group_scaled_dot_product_core.sv */
// Top level of the ternary group-scaled dot product core.
// Depends on tgsd_pkg, tgsd_lane, tgsd_merge and tgsd_mac.
//
// Usage: each input transfer carries one packed byte of four ternary codes, the
// four matching activations, the group scale and a last-byte flag. Code 01 adds
// the activation, code 10 subtracts it, the others skip; slots at or beyond the
// active column count do nothing. A group partial is scaled and added to the row
// sum when min(group_bytes, 1024) bytes are done or on the last byte. Only a last
// byte yields an output transfer: the dot product and the add, sub and skip counts.
// Four lanes decode one byte per cycle; one item is accepted every cycle unless the output stalls.
// The path is four registers deep (lanes, merge, multiply, output register); a
// result passes through them in that order once its last byte is transferred in.
// The user writes configuration through cfg_we, cfg_index and cfg_data only while idle; the block has no check.
// Reset clears all row state and sets the active column count to 4096 and
// group_bytes to 16.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps filling its empty stages; in_ready drops once no stage is free.
module ternary_group_scaled_dot_product_core import tgsd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*LANES-1:0]        packed_codes,
  input  logic signed [ACT_W-1:0]   act0,
  input  logic signed [ACT_W-1:0]   act1,
  input  logic signed [ACT_W-1:0]   act2,
  input  logic signed [ACT_W-1:0]   act3,
  input  logic signed [SCALE_W-1:0] group_scale,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ACC_W-1:0]   dot_result,
  output logic [CNT_W-1:0]          add_count,
  output logic [CNT_W-1:0]          sub_count,
  output logic [CNT_W-1:0]          skip_count
);

  logic [COL_W-1:0]          active_cols;
  logic [GB_W-1:0]           group_bytes;
  logic [COL_W-1:0]          column_index;
  logic [BIG_W-1:0]          bytes_in_group;
  logic [COL_W-1:0]          column_index_next;
  logic [BIG_W-1:0]          bytes_in_group_next;
  logic [COL_W-1:0]          limit;
  logic [COL_W:0]            col_inc;
  logic [GB_W-1:0]           big_inc;
  logic                      closes;
  logic                      accept;
  logic signed [ACT_W-1:0]   acts [LANES];
  logic                      col_ok [LANES];
  lane_t                     lanes [LANES];
  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic                      fold1;
  logic                      last1;
  logic signed [SCALE_W-1:0] scale1;
  logic                      last3;
  logic                      adv1;
  logic                      adv2;
  logic                      adv3;
  logic                      load2;
  logic                      load3;
  merge_t                    grp;

  assign adv3     = v3 && (!last3 || !out_valid || out_ready);
  assign load3    = !v3 || adv3;
  assign adv2     = v2 && load3;
  assign load2    = !v2 || adv2;
  assign adv1     = v1 && load2;
  assign in_ready = !v1 || adv1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cols <= RST_ACTIVE_COLS;
      group_bytes <= RST_GROUP_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_COLS: active_cols <= cfg_data[COL_W-1:0];
        REG_GROUP_BYTES: group_bytes <= cfg_data[GB_W-1:0];
      endcase
    end
  end

  assign limit   = (active_cols > MAX_COLUMNS) ? MAX_COLUMNS : active_cols;
  assign col_inc = {1'b0, column_index} + (COL_W+1)'(LANES);
  assign big_inc = {1'b0, bytes_in_group} + GB_W'(1);
  assign closes  = (big_inc >= group_bytes) || (big_inc >= MAX_GROUP_BYTES);

  always_comb begin
    if (last_byte) begin
      column_index_next = '0;
    end else if (col_inc > {1'b0, MAX_COLUMNS}) begin
      column_index_next = MAX_COLUMNS;
    end else begin
      column_index_next = col_inc[COL_W-1:0];
    end
    if (last_byte || closes) begin
      bytes_in_group_next = '0;
    end else begin
      bytes_in_group_next = big_inc[BIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      bytes_in_group <= '0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        column_index   <= column_index_next;
        bytes_in_group <= bytes_in_group_next;
      end
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (load2) begin
        v2 <= adv1;
      end
      if (adv3 && last3) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fold1  <= closes || last_byte;
      last1  <= last_byte;
      scale1 <= group_scale;
    end
  end

  assign acts[0] = act0;
  assign acts[1] = act1;
  assign acts[2] = act2;
  assign acts[3] = act3;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign col_ok[g] = ({1'b0, column_index} + (COL_W+1)'(g)) < {1'b0, limit};

    tgsd_lane u_lane (
      .clk    (clk),
      .load   (accept),
      .code   (packed_codes[2*g+1:2*g]),
      .act    (acts[g]),
      .col_ok (col_ok[g]),
      .res    (lanes[g])
    );
  end

  tgsd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .take     (adv1),
    .lanes    (lanes),
    .fold_in  (fold1),
    .last_in  (last1),
    .scale_in (scale1),
    .res      (grp)
  );

  tgsd_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .take       (adv2),
    .grp        (grp),
    .v3         (v3),
    .last3      (last3),
    .load3      (load3),
    .adv3       (adv3),
    .dot_result (dot_result),
    .add_count  (add_count),
    .sub_count  (sub_count),
    .skip_count (skip_count)
  );

endmodule
